[rtl/pcga_pkg.sv]
// Shared types and constants for the producer/consumer grant arbiter.
// No dependencies; the interfaces, the top level and pcga_ctrl import this package.
package pcga_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int ID_W            = 8;

    localparam logic [ID_W-1:0] PRODUCER_ID_MAX_RST = 8'd2;

    localparam logic OP_REQUEST = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic QSEL_PROD = 1'b0;
    localparam logic QSEL_CONS = 1'b1;

    typedef struct packed {
        logic            grant_valid;
        logic [ID_W-1:0] grant_id;
        logic            queue_full;
        logic            not_found;
    } t_result;

endpackage

[rtl/pcga_in_if.sv]
// Valid/ready channel that carries one request or release word.
// Depends on pcga_pkg for the id width.
interface pcga_in_if import pcga_pkg::*; ();
    logic            valid;
    logic            ready;
    logic            opcode;
    logic [ID_W-1:0] requester_id;
    logic            slot_count;

    modport source (output valid, opcode, requester_id, slot_count, input ready);
    modport sink   (input valid, opcode, requester_id, slot_count, output ready);
endinterface

[rtl/pcga_out_if.sv]
// Valid/ready channel that carries one result word.
// Depends on pcga_pkg for the id width.
interface pcga_out_if import pcga_pkg::*; ();
    logic            valid;
    logic            ready;
    logic            grant_valid;
    logic [ID_W-1:0] grant_id;
    logic            queue_full;
    logic            not_found;

    modport source (output valid, grant_valid, grant_id, queue_full, not_found,
                    input ready);
    modport sink   (input valid, grant_valid, grant_id, queue_full, not_found,
                    output ready);
endinterface

[rtl/pcga_cfg_if.sv]
// Valid/ready write channel for the producer id limit register.
// Depends on pcga_pkg for the id width.
interface pcga_cfg_if import pcga_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [ID_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

[rtl/producer_consumer_grant_arbiter.sv]
// Producer/consumer grant arbiter: two id queues in one RAM, a sequencer, output register.
// A request is written to the tail of its queue and then finishes; a release searches its
// queue entry by entry (a RAM read and a compare), shifts the later entries down when the
// id is found (a read and a write each) and then reads a queue head for the grant.
// One word is in work at a time; the next word can be taken in the cycle after a result
// is loaded, even while it waits. Reset clears counts and output valid, limit becomes 2.
module producer_consumer_grant_arbiter import pcga_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pcga_in_if.sink     i_req,
    pcga_cfg_if.sink    i_cfg,
    pcga_out_if.source  o_res
);

    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int AW = IW + 1;

    logic [ID_W-1:0] r_pid_max;
    logic            r_out_valid;
    t_result         r_out;

    logic            w_busy;
    logic            w_accept;
    logic            w_out_free;
    logic            w_done;
    t_result         w_result;
    logic            w_we;
    logic [AW-1:0]   w_waddr;
    logic [ID_W-1:0] w_wdata;
    logic [AW-1:0]   w_raddr;
    logic [ID_W-1:0] w_rdata;

    assign i_req.ready = !w_busy;
    assign w_accept    = i_req.valid && !w_busy;
    assign i_cfg.ready = 1'b1;
    assign w_out_free  = !r_out_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pid_max   <= PRODUCER_ID_MAX_RST;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_pid_max <= i_cfg.data;
            end
            if (w_done) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_done) begin
            r_out <= w_result;
        end
    end

    pcga_ram #(
        .WIDTH (ID_W),
        .DEPTH (2 * (2 ** IW))
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    pcga_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_accept),
        .i_opcode   (i_req.opcode),
        .i_id       (i_req.requester_id),
        .i_slot     (i_req.slot_count),
        .i_is_prod  (i_req.requester_id <= r_pid_max),
        .i_out_free (w_out_free),
        .i_rdata    (w_rdata),
        .o_busy     (w_busy),
        .o_we       (w_we),
        .o_waddr    (w_waddr),
        .o_wdata    (w_wdata),
        .o_raddr    (w_raddr),
        .o_done     (w_done),
        .o_result   (w_result)
    );

    assign o_res.valid       = r_out_valid;
    assign o_res.grant_valid = r_out.grant_valid;
    assign o_res.grant_id    = r_out.grant_id;
    assign o_res.queue_full  = r_out.queue_full;
    assign o_res.not_found   = r_out.not_found;

    a_no_full_and_missing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> !(o_res.queue_full && o_res.not_found))
        else $error("Result flags both a full queue and a missing id.");

    a_zero_id_without_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.grant_valid) |-> (o_res.grant_id == '0))
        else $error("Result carries an id without a grant.");

    a_done_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> w_out_free)
        else $error("Result finished while the output register was still held.");

    a_busy_from_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_busy && !w_accept) |=> !w_busy)
        else $error("Sequencer left idle without an accepted word.");

endmodule

[rtl/pcga_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module pcga_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/pcga_ctrl.sv]
// Sequencer that appends, searches, shifts and reads the heads of both queues
// held in the shared RAM. Depends on pcga_pkg.
module pcga_ctrl import pcga_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    localparam int IW = $clog2(QUEUE_DEPTH),
    localparam int CW = $clog2(QUEUE_DEPTH + 1),
    localparam int AW = IW + 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic            i_opcode,
    input  logic [ID_W-1:0] i_id,
    input  logic            i_slot,
    input  logic            i_is_prod,
    input  logic            i_out_free,
    input  logic [ID_W-1:0] i_rdata,
    output logic            o_busy,
    output logic            o_we,
    output logic [AW-1:0]   o_waddr,
    output logic [ID_W-1:0] o_wdata,
    output logic [AW-1:0]   o_raddr,
    output logic            o_done,
    output t_result         o_result
);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_SRCH_RD   = 3'd1;
    localparam logic [2:0] S_SRCH_CMP  = 3'd2;
    localparam logic [2:0] S_SH_RD     = 3'd3;
    localparam logic [2:0] S_SH_WR     = 3'd4;
    localparam logic [2:0] S_HEAD_RD   = 3'd5;
    localparam logic [2:0] S_HEAD_WAIT = 3'd6;
    localparam logic [2:0] S_DONE      = 3'd7;

    logic [2:0]      r_state, n_state;
    logic [CW-1:0]   r_pcnt, n_pcnt;
    logic [CW-1:0]   r_ccnt, n_ccnt;
    logic [IW-1:0]   r_idx, n_idx;
    logic            r_cls, n_cls;
    logic            r_slot, n_slot;
    logic [ID_W-1:0] r_id, n_id;
    t_result         r_res, n_res;

    logic            w_in_cls;
    logic [CW-1:0]   w_in_cnt;
    logic [CW-1:0]   w_own_cnt;
    logic [CW-1:0]   w_idx_next;
    logic            w_head_q;
    logic [CW-1:0]   w_head_cnt;

    assign w_in_cls   = i_is_prod ? QSEL_PROD : QSEL_CONS;
    assign w_in_cnt   = i_is_prod ? r_pcnt : r_ccnt;
    assign w_own_cnt  = (r_cls == QSEL_PROD) ? r_pcnt : r_ccnt;
    assign w_idx_next = CW'(r_idx) + CW'(1);
    assign w_head_q   = (r_cls == QSEL_PROD) ? QSEL_CONS :
                        (r_slot ? QSEL_CONS : QSEL_PROD);
    assign w_head_cnt = (w_head_q == QSEL_PROD) ? r_pcnt : r_ccnt;

    always_comb begin
        n_state = r_state;
        n_pcnt  = r_pcnt;
        n_ccnt  = r_ccnt;
        n_idx   = r_idx;
        n_cls   = r_cls;
        n_slot  = r_slot;
        n_id    = r_id;
        n_res   = r_res;
        o_we    = 1'b0;
        o_waddr = {r_cls, r_idx};
        o_wdata = i_rdata;
        o_raddr = {r_cls, r_idx};
        o_done  = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_cls  = w_in_cls;
                    n_slot = i_slot;
                    n_id   = i_id;
                    n_idx  = '0;
                    n_res  = '0;
                    if (i_opcode == OP_REQUEST) begin
                        if (w_in_cnt < CW'(QUEUE_DEPTH)) begin
                            o_we    = 1'b1;
                            o_waddr = {w_in_cls, w_in_cnt[IW-1:0]};
                            o_wdata = i_id;
                            if (i_is_prod) begin
                                n_pcnt = r_pcnt + CW'(1);
                            end else begin
                                n_ccnt = r_ccnt + CW'(1);
                            end
                        end else begin
                            n_res.queue_full = 1'b1;
                        end
                        if (i_is_prod ? !i_slot : i_slot) begin
                            n_res.grant_valid = 1'b1;
                            n_res.grant_id    = i_id;
                        end
                        n_state = S_DONE;
                    end else if (w_in_cnt == '0) begin
                        n_res.not_found = 1'b1;
                        n_state         = S_HEAD_RD;
                    end else begin
                        n_state = S_SRCH_RD;
                    end
                end
            end
            S_SRCH_RD: begin
                o_raddr = {r_cls, r_idx};
                n_state = S_SRCH_CMP;
            end
            S_SRCH_CMP: begin
                if (i_rdata == r_id) begin
                    n_state = S_SH_RD;
                end else if (w_idx_next == w_own_cnt) begin
                    n_res.not_found = 1'b1;
                    n_state         = S_HEAD_RD;
                end else begin
                    n_idx   = r_idx + IW'(1);
                    n_state = S_SRCH_RD;
                end
            end
            S_SH_RD: begin
                if (w_idx_next < w_own_cnt) begin
                    o_raddr = {r_cls, r_idx + IW'(1)};
                    n_state = S_SH_WR;
                end else begin
                    if (r_cls == QSEL_PROD) begin
                        n_pcnt = r_pcnt - CW'(1);
                    end else begin
                        n_ccnt = r_ccnt - CW'(1);
                    end
                    n_state = S_HEAD_RD;
                end
            end
            S_SH_WR: begin
                o_we    = 1'b1;
                o_waddr = {r_cls, r_idx};
                o_wdata = i_rdata;
                n_idx   = r_idx + IW'(1);
                n_state = S_SH_RD;
            end
            S_HEAD_RD: begin
                o_raddr = {w_head_q, {IW{1'b0}}};
                if (w_head_cnt != '0) begin
                    n_state = S_HEAD_WAIT;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_HEAD_WAIT: begin
                n_res.grant_valid = 1'b1;
                n_res.grant_id    = i_rdata;
                n_state           = S_DONE;
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pcnt  <= '0;
            r_ccnt  <= '0;
        end else begin
            r_state <= n_state;
            r_pcnt  <= n_pcnt;
            r_ccnt  <= n_ccnt;
        end
        r_idx  <= n_idx;
        r_cls  <= n_cls;
        r_slot <= n_slot;
        r_id   <= n_id;
        r_res  <= n_res;
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_result = r_res;

endmodule
